// ----- rtl/cspg_pkg.sv -----
// Shared widths, constants, codes and transaction types of the color spectrum pixel generator.
`timescale 1ns / 1ps

package cspg_pkg;

   // Field and datapath widths
   localparam int COORD_W = 12;
   localparam int SIZE_W  = 13;
   localparam int CHAN_W  = 8;
   localparam int Q16_W   = 17;   // 0..65536 and hue 0..92159
   localparam int NUM_W   = 29;   // dividend of the coordinate dividers
   localparam int QUO_W   = 17;   // quotient of the coordinate dividers
   localparam int SIZE_MAX = (1 << SIZE_W) - 1;

   // Fixed-point constants
   localparam logic [Q16_W-1:0] ONE_Q16    = 17'd65536;
   localparam logic [Q16_W-1:0] HUE_FULL   = 17'd92160;
   localparam logic [Q16_W-1:0] HUE_SECTOR = 17'd15360;

   // Output queue depth and the credit counter that tracks it
   localparam int OUT_DEPTH = 32;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

   // Register indexes
   localparam logic [2:0] REG_LAYOUT = 3'd0;
   localparam logic [2:0] REG_MODE   = 3'd1;
   localparam logic [2:0] REG_RED    = 3'd2;
   localparam logic [2:0] REG_GREEN  = 3'd3;
   localparam logic [2:0] REG_BLUE   = 3'd4;
   localparam logic [2:0] REG_WIDTH  = 3'd5;
   localparam logic [2:0] REG_HEIGHT = 3'd6;

   // Layouts and color modes
   localparam logic       LAYOUT_SQUARE = 1'b0;
   localparam logic       LAYOUT_STRIP  = 1'b1;
   localparam logic [2:0] MODE_RED   = 3'd0;
   localparam logic [2:0] MODE_GREEN = 3'd1;
   localparam logic [2:0] MODE_BLUE  = 3'd2;
   localparam logic [2:0] MODE_HUE   = 3'd3;
   localparam logic [2:0] MODE_SAT   = 3'd4;
   localparam logic [2:0] MODE_VAL   = 3'd5;

   // Work kinds decided by the front end
   localparam logic [1:0] KIND_BLACK      = 2'd0;
   localparam logic [1:0] KIND_SQUARE_RGB = 2'd1;
   localparam logic [1:0] KIND_STRIP_RGB  = 2'd2;
   localparam logic [1:0] KIND_HSV        = 2'd3;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
   } cspg_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
   } cspg_rsp_type;

   // Active configuration with effective sizes and derived base HSV
   typedef struct packed {
      logic              layout;
      logic [2:0]        mode;
      logic [CHAN_W-1:0] base_red;
      logic [CHAN_W-1:0] base_green;
      logic [CHAN_W-1:0] base_blue;
      logic [SIZE_W-1:0] eff_w;
      logic [SIZE_W-1:0] eff_h;
      logic [Q16_W-1:0]  base_hue;
      logic [Q16_W-1:0]  base_sat;
      logic [Q16_W-1:0]  base_val;
   } cspg_cfg_type;

   // Entry of the queue between front and back
   typedef struct packed {
      logic [1:0]       kind;
      logic [NUM_W-1:0] num_a;
      logic [NUM_W-1:0] num_b;
   } cspg_op_type;

endpackage

// ----- rtl/cspg_setup.sv -----
// Configuration registers and the serial divider that derives the base color's HSV.
`timescale 1ns / 1ps

module cspg_setup import cspg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [SIZE_W-1:0] csr_wdata,
   input  logic [SIZE_W-1:0] side_limit,
   output cspg_cfg_type      cfg,
   output logic              busy
);

   localparam int DIV_W = 24;
   localparam logic       ST_IDLE = 1'b0;
   localparam logic       ST_RUN  = 1'b1;
   localparam logic [1:0] JOB_SAT = 2'd1;
   localparam logic [1:0] JOB_HUE = 2'd2;

   logic              layout_ff, layout_in;
   logic [2:0]        mode_ff, mode_in;
   logic [CHAN_W-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [SIZE_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [Q16_W-1:0]  hue_ff, hue_in, sat_ff, sat_in, val_ff, val_in;
   logic              pending_ff, pending_in;
   logic              state_ff, state_in;
   logic [1:0]        job_ff, job_in;
   logic [4:0]        step_ff, step_in;
   logic [DIV_W-1:0]  num_ff, num_in, quo_ff, quo_in;
   logic [CHAN_W-1:0] rem_ff, rem_in, den_ff, den_in;

   logic              wr;
   logic [CHAN_W-1:0] mx, mn, dd, mag;
   logic              neg;
   logic [Q16_W-1:0]  hue_base;
   logic [CHAN_W:0]   rem_try;
   logic              ge;
   logic [DIV_W-1:0]  quo_done;
   logic [Q16_W-1:0]  q17;
   logic [DIV_W-1:0]  job_num;
   logic [CHAN_W-1:0] job_den;

   assign csr_ready = 1'b1;
   assign wr = csr_valid;
   assign busy = pending_ff | (state_ff == ST_RUN);

   // Max, min and the signed hue difference of the base color
   always_comb begin
      mx = red_ff;
      if (green_ff > mx) mx = green_ff;
      if (blue_ff > mx) mx = blue_ff;
      mn = red_ff;
      if (green_ff < mn) mn = green_ff;
      if (blue_ff < mn) mn = blue_ff;
      dd = mx - mn;
      priority if (red_ff == mx) begin
         neg = green_ff < blue_ff;
         mag = neg ? blue_ff - green_ff : green_ff - blue_ff;
         hue_base = '0;
      end else if (green_ff == mx) begin
         neg = blue_ff < red_ff;
         mag = neg ? red_ff - blue_ff : blue_ff - red_ff;
         hue_base = 17'd30720;
      end else begin
         neg = red_ff < green_ff;
         mag = neg ? green_ff - red_ff : red_ff - green_ff;
         hue_base = 17'd61440;
      end
   end

   // Dividend and divisor of each job
   always_comb begin
      unique case (job_in)
         JOB_SAT: begin
            job_num = {dd, 16'h0};
            job_den = mx;
         end
         default: begin
            job_num = DIV_W'(({14'h0, mag} << 14) - ({14'h0, mag} << 10));
            job_den = dd;
         end
      endcase
   end

   // One quotient bit per cycle
   assign rem_try  = {rem_ff, num_ff[DIV_W-1]};
   assign ge       = rem_try >= {1'b0, den_ff};
   assign quo_done = {quo_ff[DIV_W-2:0], ge};
   assign q17      = quo_done[Q16_W-1:0];

   always_comb begin
      layout_in  = layout_ff;
      mode_in    = mode_ff;
      red_in     = red_ff;
      green_in   = green_ff;
      blue_in    = blue_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      hue_in     = hue_ff;
      sat_in     = sat_ff;
      // mx*65536/255 = mx*257, plus one when mx is 255
      val_in     = Q16_W'({mx, mx}) + Q16_W'(mx == 8'hFF);
      pending_in = pending_ff;
      state_in   = state_ff;
      job_in     = job_ff;
      step_in    = step_ff;
      num_in     = num_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      den_in     = den_ff;

      // Sequencer: restart both jobs whenever a write is pending
      if (pending_ff) begin
         pending_in = 1'b0;
         state_in   = ST_RUN;
         job_in     = JOB_SAT;
         step_in    = '0;
         num_in     = job_num;
         den_in     = job_den;
         rem_in     = '0;
         quo_in     = '0;
      end else if (state_ff == ST_RUN) begin
         num_in  = num_ff << 1;
         quo_in  = quo_done;
         rem_in  = ge ? CHAN_W'(rem_try - {1'b0, den_ff}) : rem_try[CHAN_W-1:0];
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(DIV_W - 1)) begin
            unique case (job_ff)
               JOB_SAT: sat_in = (mx == '0) ? '0 : q17;
               default: begin
                  if (dd == '0) hue_in = '0;
                  else if (hue_base == '0) hue_in = (neg && q17 != '0) ? HUE_FULL - q17 : q17;
                  else hue_in = neg ? hue_base - q17 : hue_base + q17;
               end
            endcase
            step_in = '0;
            rem_in  = '0;
            quo_in  = '0;
            if (job_ff == JOB_HUE) begin
               state_in = ST_IDLE;
            end else begin
               job_in = job_ff + 2'd1;
               num_in = job_num;
               den_in = job_den;
            end
         end
      end

      // Register writes
      if (wr) begin
         pending_in = 1'b1;
         unique case (csr_index)
            REG_LAYOUT: layout_in = csr_wdata[0];
            REG_MODE:   mode_in   = csr_wdata[2:0];
            REG_RED:    red_in    = csr_wdata[CHAN_W-1:0];
            REG_GREEN:  green_in  = csr_wdata[CHAN_W-1:0];
            REG_BLUE:   blue_in   = csr_wdata[CHAN_W-1:0];
            REG_WIDTH:  width_in  = csr_wdata;
            REG_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff  <= LAYOUT_SQUARE;
         mode_ff    <= MODE_HUE;
         red_ff     <= 8'd255;
         green_ff   <= 8'd255;
         blue_ff    <= 8'd255;
         width_ff   <= 13'd256;
         height_ff  <= 13'd256;
         pending_ff <= 1'b1;
         state_ff   <= ST_IDLE;
         job_ff     <= JOB_SAT;
         step_ff    <= '0;
      end else begin
         layout_ff  <= layout_in;
         mode_ff    <= mode_in;
         red_ff     <= red_in;
         green_ff   <= green_in;
         blue_ff    <= blue_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         pending_ff <= pending_in;
         state_ff   <= state_in;
         job_ff     <= job_in;
         step_ff    <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      hue_ff <= hue_in;
      sat_ff <= sat_in;
      val_ff <= val_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // Effective configuration
   always_comb begin
      cfg.layout     = layout_ff;
      cfg.mode       = mode_ff;
      cfg.base_red   = red_ff;
      cfg.base_green = green_ff;
      cfg.base_blue  = blue_ff;
      cfg.eff_w      = (width_ff == '0) ? SIZE_W'(1) :
                       (width_ff > side_limit) ? side_limit : width_ff;
      cfg.eff_h      = (height_ff == '0) ? SIZE_W'(1) :
                       (height_ff > side_limit) ? side_limit : height_ff;
      cfg.base_hue   = hue_ff;
      cfg.base_sat   = sat_ff;
      cfg.base_val   = val_ff;
   end

endmodule

// ----- rtl/cspg_front.sv -----
// Front end: clamps coordinates, classifies the work and queues divider operands.
`timescale 1ns / 1ps

module cspg_front import cspg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  cspg_req_type req_data,
   input  cspg_cfg_type cfg,
   input  logic         take,
   output cspg_op_type  head,
   output logic         head_valid,
   output logic         queue_full
);

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   cspg_op_type         queue_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   logic [COORD_W-1:0]  xc, yc;
   logic [SIZE_W-1:0]   dx, dy;
   logic [NUM_W-1:0]    x_frac, y_frac, x_hue, y_hue, x_rgb, y_rgb, y_base;
   logic [CHAN_W-1:0]   base_ch;
   cspg_op_type         op;

   // Clamp coordinates to the effective size
   assign xc = ({1'b0, req_data.pixel_x} > cfg.eff_w) ? COORD_W'(cfg.eff_w) : req_data.pixel_x;
   assign yc = ({1'b0, req_data.pixel_y} > cfg.eff_h) ? COORD_W'(cfg.eff_h) : req_data.pixel_y;
   assign dx = cfg.eff_w - {1'b0, xc};
   assign dy = cfg.eff_h - {1'b0, yc};

   // Dividends: c*65536, c*92160, 255*(n-c), base*y
   assign x_frac = NUM_W'({xc, 16'h0});
   assign y_frac = NUM_W'({yc, 16'h0});
   assign x_hue  = (NUM_W'(xc) << 16) + (NUM_W'(xc) << 14) + (NUM_W'(xc) << 13)
                 + (NUM_W'(xc) << 11);
   assign y_hue  = (NUM_W'(yc) << 16) + (NUM_W'(yc) << 14) + (NUM_W'(yc) << 13)
                 + (NUM_W'(yc) << 11);
   assign x_rgb  = (NUM_W'(dx) << 8) - NUM_W'(dx);
   assign y_rgb  = (NUM_W'(dy) << 8) - NUM_W'(dy);
   assign y_base = NUM_W'(base_ch * yc);

   always_comb begin
      unique case (cfg.mode)
         MODE_RED:   base_ch = cfg.base_red;
         MODE_GREEN: base_ch = cfg.base_green;
         default:    base_ch = cfg.base_blue;
      endcase
   end

   // Classify
   always_comb begin
      op.num_a = '0;
      op.num_b = '0;
      if (cfg.mode > MODE_VAL) begin
         op.kind = KIND_BLACK;
      end else if (cfg.layout == LAYOUT_SQUARE) begin
         if (cfg.mode < MODE_HUE) begin
            op.kind  = KIND_SQUARE_RGB;
            op.num_a = x_rgb;
            op.num_b = y_rgb;
         end else begin
            op.kind  = KIND_HSV;
            op.num_a = (cfg.mode == MODE_HUE) ? x_frac : x_hue;
            op.num_b = y_frac;
         end
      end else begin
         if (cfg.mode < MODE_HUE) begin
            op.kind  = KIND_STRIP_RGB;
            op.num_b = y_base;
         end else begin
            op.kind  = KIND_HSV;
            op.num_b = (cfg.mode == MODE_HUE) ? y_hue : y_frac;
         end
      end
   end

   // Operand queue
   assign head       = queue_ff[rd_ptr_ff];
   assign head_valid = count_ff != '0;
   assign queue_full = count_ff == (QPTR_W+1)'(QDEPTH);

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(accept) - (QPTR_W+1)'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) queue_ff[wr_ptr_ff] <= op;
   end

endmodule

// ----- rtl/cspg_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module cspg_div_pipe import cspg_pkg::*; (
   input  logic              clock,
   input  logic [NUM_W-1:0]  num,
   input  logic [SIZE_W-1:0] den,
   output logic [QUO_W-1:0]  quot
);

   logic [NUM_W-1:0] rem_ff [QUO_W-1];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int BIT = QUO_W - 1 - k;
      logic [NUM_W-1:0] rem_prev;
      logic [QUO_W-1:0] quo_prev, quo_in;
      logic [NUM_W:0]   sub_val;
      logic             ge;

      if (k == 0) begin : g_first
         assign rem_prev = num;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      // Subtract the divisor aligned to this quotient bit
      assign sub_val = (NUM_W+1)'(den) << BIT;
      assign ge      = {1'b0, rem_prev} >= sub_val;
      assign quo_in  = quo_prev | (ge ? (QUO_W'(1) << BIT) : '0);

      always_ff @(posedge clock) begin
         quo_ff[k] <= quo_in;
      end

      if (k < QUO_W - 1) begin : g_rem
         logic [NUM_W-1:0] rem_in;
         assign rem_in = ge ? NUM_W'({1'b0, rem_prev} - sub_val) : rem_prev;
         always_ff @(posedge clock) begin
            rem_ff[k] <= rem_in;
         end
      end
   end

   assign quot = quo_ff[QUO_W-1];

endmodule

// ----- rtl/cspg_back.sv -----
// Back end: coordinate dividers, HSV-to-RGB pipeline and result queue with credit control.
`timescale 1ns / 1ps

module cspg_back import cspg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cspg_cfg_type cfg,
   input  cspg_op_type  head,
   input  logic         head_valid,
   output logic         take,
   input  logic         pop,
   output logic         empty,
   output cspg_rsp_type rsp_data
);

   typedef struct packed {
      logic              direct;
      logic [23:0]       rgb;
      logic              s_zero;
      logic [2:0]        sec;
      logic [Q16_W-1:0]  v;
      logic [Q16_W-1:0]  vs;
   } cspg_carry_type;

   // Credit: issued transactions not yet popped
   logic [OUT_PTR_W:0]   credit_ff, credit_in;
   logic                 popped;

   // Kind delay line alongside the dividers
   logic                 tv_ff [QUO_W];
   logic [1:0]           tk_ff [QUO_W];
   logic [QUO_W-1:0]     qa, qb;

   // Stage 0: HSV or direct color
   logic                 h0_valid_ff;
   logic                 h0_direct_ff, h0_direct_in;
   logic [23:0]          h0_rgb_ff, h0_rgb_in;
   logic [Q16_W-1:0]     h0_h_ff, h0_h_in, h0_s_ff, h0_s_in, h0_v_ff, h0_v_in;
   logic [Q16_W-1:0]     ramp_a, ramp_b;
   logic [CHAN_W-1:0]    qb8;

   // Stages 1 to 4
   logic                 h1_valid_ff, h2_valid_ff, h3_valid_ff, h4_valid_ff;
   cspg_carry_type       h1_ff, h1_in, h2_ff, h3_ff, h4_ff;
   logic [13:0]          h1_rem_ff, h1_rem_in;
   logic [Q16_W-1:0]     hw;
   logic [2:0]           sec;
   logic [33:0]          vs_full;
   logic [19:0]          h2_a_ff, h2_a_in;
   logic [15:0]          h2_q0_ff, h2_q0_in;
   logic [35:0]          recip;
   logic [15:0]          h3_f_ff, h3_f_in;
   logic [19:0]          chk;
   logic [Q16_W-1:0]     h4_vsf_ff, h4_vsf_in;
   logic [32:0]          vsf_full;

   // Final channel math
   logic [CHAN_W-1:0]    p_ch, q_ch, t_ch, w_ch;
   cspg_rsp_type         result;

   // Result queue
   cspg_rsp_type         fifo_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [OUT_PTR_W:0]   cnt_ff, cnt_in;

   function automatic logic [CHAN_W-1:0] ch8(input logic [Q16_W-1:0] x);
      logic [24:0] m;
      m = (25'(x) << 8) - 25'(x);
      return CHAN_W'(m >> 16);
   endfunction

   // Issue from the operand queue while the result queue has room
   assign popped    = pop & ~empty;
   assign take      = head_valid & (credit_ff != (OUT_PTR_W+1)'(OUT_DEPTH));
   assign credit_in = credit_ff + (OUT_PTR_W+1)'(take) - (OUT_PTR_W+1)'(popped);

   cspg_div_pipe u_div_a (
      .clock (clock),
      .num   (head.num_a),
      .den   (cfg.eff_w),
      .quot  (qa)
   );

   cspg_div_pipe u_div_b (
      .clock (clock),
      .num   (head.num_b),
      .den   (cfg.eff_h),
      .quot  (qb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUO_W; i++) tv_ff[i] <= 1'b0;
      end else begin
         tv_ff[0] <= take;
         for (int i = 1; i < QUO_W; i++) tv_ff[i] <= tv_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      tk_ff[0] <= head.kind;
      for (int i = 1; i < QUO_W; i++) tk_ff[i] <= tk_ff[i-1];
   end

   // Stage 0: pick channels or HSV operands from the quotients
   assign ramp_a = ONE_Q16 - qa;
   assign ramp_b = ONE_Q16 - qb;
   assign qb8    = qb[CHAN_W-1:0];

   always_comb begin
      h0_direct_in = 1'b1;
      h0_rgb_in    = '0;
      h0_h_in      = '0;
      h0_s_in      = '0;
      h0_v_in      = '0;
      unique case (tk_ff[QUO_W-1])
         KIND_SQUARE_RGB: begin
            unique case (cfg.mode)
               MODE_RED:   h0_rgb_in = {cfg.base_red, qb8, qa[CHAN_W-1:0]};
               MODE_GREEN: h0_rgb_in = {qb8, cfg.base_green, qa[CHAN_W-1:0]};
               default:    h0_rgb_in = {qb8, qa[CHAN_W-1:0], cfg.base_blue};
            endcase
         end
         KIND_STRIP_RGB: begin
            unique case (cfg.mode)
               MODE_RED:   h0_rgb_in = {cfg.base_red - qb8, 16'h0};
               MODE_GREEN: h0_rgb_in = {8'h0, cfg.base_green - qb8, 8'h0};
               default:    h0_rgb_in = {16'h0, cfg.base_blue - qb8};
            endcase
         end
         KIND_HSV: begin
            h0_direct_in = 1'b0;
            if (cfg.layout == LAYOUT_SQUARE) begin
               unique case (cfg.mode)
                  MODE_HUE: begin
                     h0_h_in = cfg.base_hue;
                     h0_s_in = ramp_b;
                     h0_v_in = ramp_a;
                  end
                  MODE_SAT: begin
                     h0_h_in = qa;
                     h0_s_in = cfg.base_sat;
                     h0_v_in = ramp_b;
                  end
                  default: begin
                     h0_h_in = qa;
                     h0_s_in = ramp_b;
                     h0_v_in = cfg.base_val;
                  end
               endcase
            end else begin
               unique case (cfg.mode)
                  MODE_HUE: begin
                     h0_h_in = qb;
                     h0_s_in = ONE_Q16;
                     h0_v_in = ONE_Q16;
                  end
                  MODE_SAT: begin
                     h0_s_in = ramp_b;
                     h0_v_in = ONE_Q16;
                  end
                  default: h0_v_in = ramp_b;
               endcase
            end
         end
         default: ;
      endcase
   end

   // Stage 1: hue wrap, sector, remainder and V*S
   assign hw = (h0_h_ff >= HUE_FULL) ? '0 : h0_h_ff;
   assign sec = 3'(hw >= HUE_SECTOR) + 3'(hw >= 17'd30720) + 3'(hw >= 17'd46080)
              + 3'(hw >= 17'd61440) + 3'(hw >= 17'd76800);
   assign h1_rem_in = 14'(hw - 17'(sec) * HUE_SECTOR);
   assign vs_full   = 34'(h0_v_ff) * 34'(h0_s_ff);

   always_comb begin
      h1_in.direct = h0_direct_ff;
      h1_in.rgb    = h0_rgb_ff;
      h1_in.s_zero = h0_s_ff == '0;
      h1_in.sec    = sec;
      h1_in.v      = h0_v_ff;
      h1_in.vs     = (18'(vs_full >> 16) > 18'(h0_v_ff)) ? h0_v_ff : Q16_W'(vs_full >> 16);
   end

   // Stage 2: f estimate, (rem*64)/15 by reciprocal
   assign h2_a_in  = {h1_rem_ff, 6'h0};
   assign recip    = 36'(h2_a_in) * 36'd34952;
   assign h2_q0_in = 16'(recip >> 19);

   // Stage 3: one correction step
   assign chk     = h2_a_ff - ((20'(h2_q0_ff) << 4) - 20'(h2_q0_ff));
   assign h3_f_in = h2_q0_ff + 16'(chk >= 20'd15);

   // Stage 4: V*S*f
   assign vsf_full  = 33'(h3_ff.vs) * 33'(h3_f_ff);
   assign h4_vsf_in = Q16_W'(vsf_full >> 16);

   // Channel values and sector selection
   always_comb begin
      p_ch = ch8(h4_ff.v - h4_ff.vs);
      q_ch = ch8(h4_ff.v - h4_vsf_ff);
      t_ch = ch8(h4_ff.v - h4_ff.vs + h4_vsf_ff);
      w_ch = ch8(h4_ff.v);
      if (h4_ff.direct) begin
         result = h4_ff.rgb;
      end else if (h4_ff.s_zero) begin
         result = {w_ch, w_ch, w_ch};
      end else begin
         unique case (h4_ff.sec)
            3'd0:    result = {w_ch, t_ch, p_ch};
            3'd1:    result = {q_ch, w_ch, p_ch};
            3'd2:    result = {p_ch, w_ch, t_ch};
            3'd3:    result = {p_ch, q_ch, w_ch};
            3'd4:    result = {t_ch, p_ch, w_ch};
            default: result = {w_ch, p_ch, q_ch};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h0_valid_ff <= 1'b0;
         h1_valid_ff <= 1'b0;
         h2_valid_ff <= 1'b0;
         h3_valid_ff <= 1'b0;
         h4_valid_ff <= 1'b0;
      end else begin
         h0_valid_ff <= tv_ff[QUO_W-1];
         h1_valid_ff <= h0_valid_ff;
         h2_valid_ff <= h1_valid_ff;
         h3_valid_ff <= h2_valid_ff;
         h4_valid_ff <= h3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      h0_direct_ff <= h0_direct_in;
      h0_rgb_ff    <= h0_rgb_in;
      h0_h_ff      <= h0_h_in;
      h0_s_ff      <= h0_s_in;
      h0_v_ff      <= h0_v_in;
      h1_ff        <= h1_in;
      h1_rem_ff    <= h1_rem_in;
      h2_ff        <= h1_ff;
      h2_a_ff      <= h2_a_in;
      h2_q0_ff     <= h2_q0_in;
      h3_ff        <= h2_ff;
      h3_f_ff      <= h3_f_in;
      h4_ff        <= h3_ff;
      h4_vsf_ff    <= h4_vsf_in;
   end

   // Result queue
   assign empty    = cnt_ff == '0;
   assign rsp_data = fifo_ff[rp_ff];

   always_comb begin
      wp_in  = h4_valid_ff ? wp_ff + 1'b1 : wp_ff;
      rp_in  = popped ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (OUT_PTR_W+1)'(h4_valid_ff) - (OUT_PTR_W+1)'(popped);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff     <= '0;
         rp_ff     <= '0;
         cnt_ff    <= '0;
         credit_ff <= '0;
      end else begin
         wp_ff     <= wp_in;
         rp_ff     <= rp_in;
         cnt_ff    <= cnt_in;
         credit_ff <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (h4_valid_ff) fifo_ff[wp_ff] <= result;
   end

   // Credit never exceeds the queue depth
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= (OUT_PTR_W+1)'(OUT_DEPTH))
      else $error("credit counter above result queue depth");

   // Every queued transaction was covered by a credit
   a_queue_within_credit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= credit_ff)
      else $error("result queue holds more than was issued");

   // A finished transaction always finds room
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      h4_valid_ff |-> (cnt_ff != (OUT_PTR_W+1)'(OUT_DEPTH)))
      else $error("result queue written while full");

   // An issued transaction reaches the result queue after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      take |=> ##21 h4_valid_ff)
      else $error("issued transaction lost in the pipeline");

endmodule

// ----- rtl/color_spectrum_pixel_generator.sv -----
// Top level of the color spectrum pixel generator.
//
// Usage:
//   Input queue: drive req_data (pixel_x, pixel_y) and raise push; the
//   transaction is taken at a clock edge where push is high and full is low.
//   Result queue: while empty is low, rsp_data holds the oldest pixel color
//   (out_red, out_green, out_blue); raise pop to take it.
//   Configuration: csr_valid with csr_index and csr_wdata writes one register;
//   csr_ready is always high. Write only while no pixel is in flight.
// Timing:
//   One pixel per cycle sustained. A pixel reaches the result side through
//   the operand queue, the 17-stage coordinate dividers, five HSV-to-RGB
//   stages and the result queue write.
//   After reset and after every register write, full stays high while a
//   serial divider derives the base color's saturation and hue (two
//   24-step divisions).
// Stalls: results collect in a 32-entry queue; when it is committed, issue
//   stops, a 4-entry operand queue fills and full rises. Nothing is dropped.
`timescale 1ns / 1ps

module color_spectrum_pixel_generator import cspg_pkg::*; #(
   parameter int MAX_SIDE = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  cspg_req_type      req_data,
   output logic              empty,
   input  logic              pop,
   output cspg_rsp_type      rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [SIZE_W-1:0] csr_wdata
);

   localparam logic [SIZE_W-1:0] SIDE_LIMIT =
      (MAX_SIDE > SIZE_MAX) ? SIZE_W'(SIZE_MAX) : SIZE_W'(MAX_SIDE);

   cspg_cfg_type cfg;
   cspg_op_type  head;
   logic         busy, head_valid, queue_full, take, accept;

   // Hold off input while the base color is derived or a write is under way
   assign full   = queue_full | busy | csr_valid;
   assign accept = push & ~full;

   cspg_setup u_setup (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .side_limit (SIDE_LIMIT),
      .cfg        (cfg),
      .busy       (busy)
   );

   cspg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .cfg        (cfg),
      .take       (take),
      .head       (head),
      .head_valid (head_valid),
      .queue_full (queue_full)
   );

   cspg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .head_valid (head_valid),
      .take       (take),
      .pop        (pop),
      .empty      (empty),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- verif/color_spectrum_pixel_generator_tb.sv -----
// Self-checking testbench for the color spectrum pixel generator: directed table plus random phases.
`timescale 1ns / 1ps

module color_spectrum_pixel_generator_tb;
   import cspg_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int RANDOM_PHASES  = 10;
   localparam int PIXELS_PER_PHASE = 80;
   localparam logic [2:0] REG_UNUSED = 3'd7;

   // Directed stimulus row: a register write or a pixel, with an optional typed color
   typedef struct {
      bit                is_write;
      logic [2:0]        index;
      logic [SIZE_W-1:0] wdata;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      bit                known;
      cspg_rsp_type      color;
   } directed_row_type;

   logic              clock;
   logic              reset;
   logic              push;
   logic              full;
   cspg_req_type      req_data;
   logic              empty;
   logic              pop;
   cspg_rsp_type      rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [2:0]        csr_index;
   logic [SIZE_W-1:0] csr_wdata;

   // Shadow of the block's registers
   logic              sh_layout;
   logic [2:0]        sh_mode;
   logic [7:0]        sh_red, sh_green, sh_blue;
   logic [SIZE_W-1:0] sh_width, sh_height;

   cspg_rsp_type  pixel_expect_q[$];
   directed_row_type directed_rows[$];
   int  error_count;
   int  pixels_sent;
   int  colors_checked;
   int  writes_done;
   int  idle_cycles;
   bit  quiet;

   color_spectrum_pixel_generator u_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   // ---------------- color predictor ----------------
   function automatic longint side_of(input logic [SIZE_W-1:0] n);
      if (n == 0) return 1;
      if (n > 4096) return 4096;
      return n;
   endfunction

   function automatic logic [7:0] chan8(input longint q16);
      longint r;
      r = (255 * q16) >>> 16;
      return (r > 255) ? 8'd255 : r[7:0];
   endfunction

   function automatic cspg_rsp_type hsv_to_rgb(input longint h, input longint s,
                                               input longint v);
      cspg_rsp_type c;
      longint sec, f, vs, vsf;
      logic [7:0] p, q, t, w;
      if (s == 0) begin
         c.out_red = chan8(v);
         c.out_green = c.out_red;
         c.out_blue = c.out_red;
         return c;
      end
      if (h >= 92160) h = 0;
      sec = h / 15360;
      f = ((h % 15360) * 65536) / 15360;
      vs = (v * s) >>> 16;
      if (vs > v) vs = v;
      vsf = (vs * f) >>> 16;
      p = chan8(v - vs);
      q = chan8(v - vsf);
      t = chan8(v - vs + vsf);
      w = chan8(v);
      case (sec)
         0: c = '{w, t, p};
         1: c = '{q, w, p};
         2: c = '{p, w, t};
         3: c = '{p, q, w};
         4: c = '{t, p, w};
         default: c = '{w, p, q};
      endcase
      return c;
   endfunction

   // HSV of the base color, channel differences signed
   function automatic void base_color_hsv(output longint h, output longint s,
                                          output longint v);
      int r, g, b, mx, mn, d, hh;
      r = sh_red;
      g = sh_green;
      b = sh_blue;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      v = (longint'(mx) * 65536) / 255;
      s = (mx == 0) ? 0 : (longint'(mx - mn) * 65536) / mx;
      h = 0;
      if (mx != mn) begin
         d = mx - mn;
         if (r == mx) begin
            hh = (15360 * (g - b)) / d;
            if (hh < 0) hh += 92160;
         end else if (g == mx) begin
            hh = 30720 + (15360 * (b - r)) / d;
         end else begin
            hh = 61440 + (15360 * (r - g)) / d;
         end
         h = hh;
      end
   endfunction

   function automatic cspg_rsp_type pixel_color(input logic [COORD_W-1:0] px,
                                                input logic [COORD_W-1:0] py);
      cspg_rsp_type c;
      longint w, hg, x, y, sy, sx, ry, rx, bh, bs, bv;
      c = '0;
      w = side_of(sh_width);
      hg = side_of(sh_height);
      x = (px > w) ? w : px;
      y = (py > hg) ? hg : py;
      sy = 65536 - (y * 65536) / hg;
      sx = 65536 - (x * 65536) / w;
      ry = (255 * (hg - y)) / hg;
      rx = (255 * (w - x)) / w;
      base_color_hsv(bh, bs, bv);
      if (sh_layout == LAYOUT_STRIP) begin
         case (sh_mode)
            MODE_RED:   c.out_red   = 8'(sh_red - (sh_red * y) / hg);
            MODE_GREEN: c.out_green = 8'(sh_green - (sh_green * y) / hg);
            MODE_BLUE:  c.out_blue  = 8'(sh_blue - (sh_blue * y) / hg);
            MODE_HUE:   c = hsv_to_rgb((92160 * y) / hg, 65536, 65536);
            MODE_SAT:   c = hsv_to_rgb(0, sy, 65536);
            MODE_VAL:   c = hsv_to_rgb(0, 0, sy);
            default:    c = '0;
         endcase
      end else begin
         case (sh_mode)
            MODE_RED:   c = '{sh_red, ry[7:0], rx[7:0]};
            MODE_GREEN: c = '{ry[7:0], sh_green, rx[7:0]};
            MODE_BLUE:  c = '{ry[7:0], rx[7:0], sh_blue};
            MODE_HUE:   c = hsv_to_rgb(bh, sy, sx);
            MODE_SAT:   c = hsv_to_rgb((92160 * x) / w, bs, sy);
            MODE_VAL:   c = hsv_to_rgb((92160 * x) / w, sy, bv);
            default:    c = '0;
         endcase
      end
      return c;
   endfunction

   // ---------------- drivers ----------------
   // Register write, only once all pixels have drained
   task automatic write_register(input logic [2:0] idx, input logic [SIZE_W-1:0] val);
      push <= 1'b0;
      wait (pixel_expect_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      writes_done++;
      case (idx)
         REG_LAYOUT: sh_layout = val[0];
         REG_MODE:   sh_mode   = val[2:0];
         REG_RED:    sh_red    = val[7:0];
         REG_GREEN:  sh_green  = val[7:0];
         REG_BLUE:   sh_blue   = val[7:0];
         REG_WIDTH:  sh_width  = val;
         REG_HEIGHT: sh_height = val;
         default: ;
      endcase
   endtask

   // One pixel transaction; push stays high for a following pixel
   task automatic send_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                             input bit known, input cspg_rsp_type color);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      push <= 1'b1;
      req_data <= '{pixel_x: px, pixel_y: py};
      do @(posedge clock); while (full);
      pixel_expect_q.push_back(known ? color : pixel_color(px, py));
      pixels_sent++;
   endtask

   // Result side: random stall bursts
   initial begin
      pop <= 1'b0;
      @(negedge reset);
      forever begin
         if (!quiet && $urandom_range(0, 7) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
      end
   end

   // Result check against the oldest expectation
   always @(posedge clock) begin
      cspg_rsp_type want;
      if (!reset && pop && !empty) begin
         colors_checked++;
         if (pixel_expect_q.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel color %h", rsp_data));
         end else begin
            want = pixel_expect_q.pop_front();
            if (rsp_data.out_red !== want.out_red)
               report_mismatch($sformatf("out_red %0d, expected %0d",
                                         rsp_data.out_red, want.out_red));
            if (rsp_data.out_green !== want.out_green)
               report_mismatch($sformatf("out_green %0d, expected %0d",
                                         rsp_data.out_green, want.out_green));
            if (rsp_data.out_blue !== want.out_blue)
               report_mismatch($sformatf("out_blue %0d, expected %0d",
                                         rsp_data.out_blue, want.out_blue));
         end
      end
   end

   // Watchdog on cycles with no transaction anywhere
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d pixels outstanding", pixel_expect_q.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // ---------------- directed table ----------------
   function automatic void add_write(input logic [2:0] idx, input logic [SIZE_W-1:0] val);
      directed_row_type r;
      r = '{default: '0};
      r.is_write = 1'b1;
      r.index = idx;
      r.wdata = val;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_pixel(input int px, input int py, input bit known = 0,
                                     input cspg_rsp_type color = '0);
      directed_row_type r;
      r = '{default: '0};
      r.px = px;
      r.py = py;
      r.known = known;
      r.color = color;
      directed_rows.push_back(r);
   endfunction

   function automatic void build_directed();
      // reset state: hue held over a white base
      add_pixel(0, 0, 1, '{8'd255, 8'd0, 8'd0});
      add_pixel(4095, 4095, 1, '{8'd0, 8'd0, 8'd0});
      add_pixel(100, 37);
      // unused mode codes give black
      add_write(REG_MODE, 6);
      add_pixel(5, 5, 1, '0);
      add_write(REG_MODE, 7);
      add_pixel(4095, 0, 1, '0);
      // red held, square
      add_write(REG_MODE, MODE_RED);
      add_write(REG_RED, 8'h12);
      add_pixel(0, 0, 1, '{8'h12, 8'd255, 8'd255});
      add_pixel(256, 256, 1, '{8'h12, 8'd0, 8'd0});
      add_pixel(77, 200);
      // strip layout
      add_write(REG_LAYOUT, LAYOUT_STRIP);
      add_pixel(0, 0, 1, '{8'h12, 8'd0, 8'd0});
      add_write(REG_MODE, MODE_GREEN);
      add_write(REG_GREEN, 8'hC3);
      add_pixel(9, 128);
      add_write(REG_MODE, MODE_BLUE);
      add_write(REG_BLUE, 8'h00);
      add_pixel(3, 255);
      add_write(REG_MODE, MODE_HUE);
      add_pixel(0, 4095);
      add_pixel(0, 255);
      // zero sizes taken as 1
      add_write(REG_WIDTH, 0);
      add_write(REG_HEIGHT, 0);
      add_write(REG_MODE, MODE_SAT);
      add_pixel(0, 0);
      add_pixel(1, 1);
      // oversized sizes clamp, out-of-range index ignored
      add_write(REG_WIDTH, 13'h1FFF);
      add_write(REG_HEIGHT, 4096);
      add_write(REG_UNUSED, 13'h1FFF);
      add_write(REG_MODE, MODE_VAL);
      add_pixel(4095, 2048);
      add_write(REG_LAYOUT, LAYOUT_SQUARE);
      add_pixel(4095, 4095);
      add_pixel(1024, 0);
      add_write(REG_MODE, MODE_SAT);
      add_pixel(2047, 3000);
      add_write(REG_MODE, MODE_HUE);
      add_pixel(12, 4000);
      add_write(REG_MODE, MODE_GREEN);
      add_pixel(4095, 1);
      add_write(REG_MODE, MODE_BLUE);
      add_pixel(2, 4094);
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 1;
         2: return 4096;
         3: return 13'h1FFF;
         4: return $urandom_range(4097, 8191);
         5: return $urandom_range(300, 4096);
         default: return $urandom_range(1, 300);
      endcase
   endfunction

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord(input logic [SIZE_W-1:0] n);
      longint s;
      s = side_of(n);
      if ($urandom_range(0, 6) == 0) return $urandom_range(0, 4095);
      return $urandom_range(0, s - 1);
   endfunction

   // ---------------- main sequence ----------------
   initial begin
      logic [7:0] ch;
      reset = 1'b1;
      push = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      quiet = 0;
      error_count = 0;
      pixels_sent = 0;
      colors_checked = 0;
      writes_done = 0;
      idle_cycles = 0;
      sh_layout = LAYOUT_SQUARE;
      sh_mode = MODE_HUE;
      sh_red = 8'd255;
      sh_green = 8'd255;
      sh_blue = 8'd255;
      sh_width = 256;
      sh_height = 256;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      build_directed();
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_write)
            write_register(directed_rows[i].index, directed_rows[i].wdata);
         else
            send_pixel(directed_rows[i].px, directed_rows[i].py,
                       directed_rows[i].known, directed_rows[i].color);
      end

      // random phases, each with a fresh configuration
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         quiet = (ph >= RANDOM_PHASES - 2);
         write_register(REG_LAYOUT, $urandom_range(0, 1));
         write_register(REG_MODE, ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7)
                                                             : $urandom_range(0, 5));
         ch = pick_channel();
         write_register(REG_RED, ch);
         // equal channels now and then to reach the gray and tie cases
         write_register(REG_GREEN, ($urandom_range(0, 3) == 0) ? ch : pick_channel());
         write_register(REG_BLUE, ($urandom_range(0, 3) == 0) ? ch : pick_channel());
         write_register(REG_WIDTH, pick_size());
         write_register(REG_HEIGHT, pick_size());
         if ($urandom_range(0, 3) == 0) write_register(REG_UNUSED, $urandom_range(0, 8191));
         repeat (PIXELS_PER_PHASE)
            send_pixel(pick_coord(sh_width), pick_coord(sh_height), 0, '0);
      end

      push <= 1'b0;
      wait (pixel_expect_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run covered %0d pixels and %0d register writes; %0d colors checked.",
               pixels_sent, writes_done, colors_checked);
      $display("All six modes, both layouts, unused modes and size clamps were exercised.");
      if (error_count == 0 && pixel_expect_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
